// ===== sv/double_ended_queue_assert.svh =====
// assertion macros for the double-ended queue
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// same-cycle implication
`define DQ_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/dq_pkg.sv =====
// types and constants shared by the double-ended queue modules
package dq_pkg;

  localparam int VALUE_W    = 32;
  localparam int MODE_W     = 3;
  localparam int OCC_W      = 7;
  localparam int STATUS_W   = 2;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 80;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_CLEAR      = 3'd4,
    MODE_QUERY      = 3'd5
  } mode_t;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_UNDER = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_OVER  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_LOAD
  } state_t;

  typedef struct packed {
    logic                load;
    logic                empty;
    logic [OCC_W-1:0]    occupancy;
    logic [STATUS_W-1:0] status;
  } dq_ctl_t;

endpackage

// ===== sv/dq_ram.sv =====
// generic single-write, single-read ram with registered read data
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/dq_ctrl.sv =====
// head and count registers, ring address arithmetic and operation sequencer
module dq_ctrl #(
  parameter int DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  dq_pkg::mode_t                 mode,
  input  logic [dq_pkg::VALUE_W-1:0]    value,
  input  logic                          out_free,
  output logic                          wr_en,
  output logic [$clog2(DEPTH)-1:0]      wr_addr,
  output logic [dq_pkg::VALUE_W-1:0]    wr_data,
  output logic [$clog2(DEPTH)-1:0]      front_addr,
  output logic [$clog2(DEPTH)-1:0]      back_addr,
  output dq_pkg::dq_ctl_t               ctl
);
  import dq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  state_t              state, state_next;
  logic [AW-1:0]       head, head_next;
  logic [CW-1:0]       count, count_next;
  logic [STATUS_W-1:0] status, status_next;
  logic                accept;
  logic                full;
  logic                empty;
  logic [AW-1:0]       head_dec;
  logic [AW-1:0]       head_inc;
  logic [CW-1:0]       cnt_m1;
  logic [AW-1:0]       tail_pos;

  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign accept   = in_valid && in_ready;
  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign head_dec = (head == '0) ? AW'(DEPTH - 1) : head - AW'(1);
  assign head_inc = (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
  assign cnt_m1   = count - CW'(1);
  assign tail_pos = ring_add(head, count[AW-1:0]);

  assign front_addr = head;
  assign back_addr  = ring_add(head, cnt_m1[AW-1:0]);
  assign wr_data    = value;

  // operation decode
  always_comb begin
    head_next   = head;
    count_next  = count;
    status_next = STAT_OK;
    wr_en       = 1'b0;
    wr_addr     = tail_pos;
    unique case (mode)
      MODE_PUSH_FRONT: begin
        if (full) begin
          status_next = STAT_OVER;
        end else begin
          head_next  = head_dec;
          count_next = count + CW'(1);
          wr_en      = accept;
          wr_addr    = head_dec;
        end
      end
      MODE_PUSH_BACK: begin
        if (full) begin
          status_next = STAT_OVER;
        end else begin
          count_next = count + CW'(1);
          wr_en      = accept;
        end
      end
      MODE_POP_FRONT: begin
        if (empty) begin
          status_next = STAT_UNDER;
        end else begin
          head_next  = head_inc;
          count_next = cnt_m1;
        end
      end
      MODE_POP_BACK: begin
        if (empty) begin
          status_next = STAT_UNDER;
        end else begin
          count_next = cnt_m1;
        end
      end
      MODE_CLEAR: begin
        head_next  = '0;
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_READ;
      end
      S_READ: state_next = S_LOAD;
      S_LOAD: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state == S_IDLE);
    ctl.load      = (state == S_LOAD) && out_free;
    ctl.empty     = empty;
    ctl.occupancy = OCC_W'(count);
    ctl.status    = status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      head   <= '0;
      count  <= '0;
      status <= STAT_OK;
    end else begin
      state <= state_next;
      if (accept) begin
        head   <= head_next;
        count  <= count_next;
        status <= status_next;
      end
    end
  end

  `include "double_ended_queue_assert.svh"

  `DQ_ASSERT_NOW(a_count_range, clk, rst, 1'b1, count <= CW'(DEPTH), "count above depth")
  `DQ_ASSERT_NOW(a_read_after_idle, clk, rst, state == S_READ, $past(state) == S_IDLE, "read without accept")
  `DQ_ASSERT_NEXT(a_empty_pop, clk, rst, accept && empty && (mode == MODE_POP_FRONT || mode == MODE_POP_BACK), count == $past(count) && head == $past(head), "pop on empty changed state")
  `DQ_ASSERT_NEXT(a_full_push, clk, rst, accept && full && (mode == MODE_PUSH_FRONT || mode == MODE_PUSH_BACK), count == $past(count) && status == STAT_OVER, "push on full not flagged")

endmodule

// ===== sv/double_ended_queue.sv =====
// an accepted word updates head and count and writes the ring store; the front and back
// entries are then read into the registered ram outputs and loaded into the output register
//   once it is free; a new word is taken only after the previous one has been loaded there
// the input is taken while a finished result waits in the output register
// reset clears head, count and valid flags; the ring store is not cleared
module double_ended_queue #(
  parameter int DEPTH = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [dq_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // value
  input  logic [dq_pkg::MODE_W-1:0]       s_axis_tuser,  // mode
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [dq_pkg::OUT_DATA_W-1:0]   m_axis_tdata   // front_value, back_value, occupancy, status
);
  import dq_pkg::*;

  localparam int AW    = $clog2(DEPTH);
  localparam int PAD_W = OUT_DATA_W - 2 * VALUE_W - OCC_W - STATUS_W;

  dq_ctl_t             ctl;
  logic                out_free;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [VALUE_W-1:0]  wr_data;
  logic [AW-1:0]       front_addr;
  logic [AW-1:0]       back_addr;
  logic [VALUE_W-1:0]  front_rd;
  logic [VALUE_W-1:0]  back_rd;
  logic [VALUE_W-1:0]  front_q;
  logic [VALUE_W-1:0]  back_q;
  logic [OCC_W-1:0]    occ_q;
  logic [STATUS_W-1:0] status_q;
  logic                out_valid;

  assign out_free = !out_valid || m_axis_tready;

  dq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .mode       (mode_t'(s_axis_tuser)),
    .value      (s_axis_tdata[VALUE_W-1:0]),
    .out_free   (out_free),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .front_addr (front_addr),
    .back_addr  (back_addr),
    .ctl        (ctl)
  );

  dq_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_ram_front (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (front_addr),
    .rd_data (front_rd)
  );

  dq_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_ram_back (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (back_addr),
    .rd_data (back_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      front_q  <= ctl.empty ? '0 : front_rd;
      back_q   <= ctl.empty ? '0 : back_rd;
      occ_q    <= ctl.occupancy;
      status_q <= ctl.status;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, status_q, occ_q, back_q, front_q};

endmodule

// ===== sim/tb_double_ended_queue.sv =====
`timescale 1ns / 100ps
// testbench for the double-ended queue: predicted results checked word by word
module tb_double_ended_queue;
  import dq_pkg::*;

  localparam int DEPTH = 64;
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
  localparam int MAX_REPORTS = 40;
  localparam int HOLD_CYCLES = 250;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0]    occupancy;
    logic [VALUE_W-1:0]  back_value;
    logic [VALUE_W-1:0]  front_value;
  } deque_view_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // value
  logic [MODE_W-1:0]     s_axis_tuser = '0;   // mode
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // front_value, back_value, occupancy, status

  // shadow deque
  logic [VALUE_W-1:0] ring_mem [DEPTH];
  int unsigned ring_head = 0;
  int unsigned ring_count = 0;
  int unsigned peak_count = 0;

  deque_view_t expected_views[$];
  int mismatches = 0;
  int words_sent = 0;
  int words_checked = 0;
  int overflow_seen = 0;
  int underflow_seen = 0;
  int hold_request = 0;
  int hold_served = 0;
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;

  double_ended_queue #(.DEPTH(DEPTH)) uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk = ~clk;

  function automatic deque_view_t deque_step(input logic [MODE_W-1:0] op,
                                             input logic [VALUE_W-1:0] val);
    deque_view_t view;
    view = '0;
    view.status = STAT_OK;
    case (op)
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        if (ring_count >= DEPTH) begin
          view.status = STAT_OVER;
        end else if (op == MODE_PUSH_FRONT) begin
          ring_head = (ring_head + DEPTH - 1) % DEPTH;
          ring_mem[ring_head] = val;
          ring_count++;
        end else begin
          ring_mem[(ring_head + ring_count) % DEPTH] = val;
          ring_count++;
        end
      end
      MODE_POP_FRONT, MODE_POP_BACK: begin
        if (ring_count == 0) begin
          view.status = STAT_UNDER;
        end else begin
          if (op == MODE_POP_FRONT) ring_head = (ring_head + 1) % DEPTH;
          ring_count--;
        end
      end
      MODE_CLEAR: begin
        ring_head = 0;
        ring_count = 0;
      end
      default: ;
    endcase
    if (ring_count != 0) begin
      view.front_value = ring_mem[ring_head];
      view.back_value = ring_mem[(ring_head + ring_count - 1) % DEPTH];
    end
    view.occupancy = ring_count[OCC_W-1:0];
    if (ring_count > peak_count) peak_count = ring_count;
    if (view.status == STAT_OVER) overflow_seen++;
    if (view.status == STAT_UNDER) underflow_seen++;
    return view;
  endfunction

  function automatic logic [VALUE_W-1:0] any_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '1;
      3: return '0;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [MODE_W-1:0] pick_mode(input int push_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return MODE_CLEAR;
    if (r < 6) return MODE_QUERY;
    if (r < 8) return $urandom_range(0, 1) ? MODE_SPARE_LO : MODE_SPARE_HI;
    if ($urandom_range(0, 99) < push_pct)
      return $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
    return $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_BACK;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_REPORTS) $display("mismatch at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  // called at a falling edge, returns at the falling edge after the word is taken
  task automatic send_word(input logic [MODE_W-1:0] op, input logic [VALUE_W-1:0] val);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= val;
    s_axis_tuser <= op;
    do @(posedge clk); while (!s_axis_tready);
    expected_views.push_back(deque_step(op, val));
    words_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_views.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_empty_deque();
    send_word(MODE_QUERY, $urandom());
    send_word(MODE_POP_FRONT, $urandom());
    send_word(MODE_POP_BACK, $urandom());
    send_word(MODE_SPARE_LO, $urandom());
    send_word(MODE_SPARE_HI, $urandom());
    send_word(MODE_CLEAR, $urandom());
    drain_results();
  endtask

  task automatic test_both_ends();
    send_word(MODE_PUSH_FRONT, 32'h8000_0000);
    send_word(MODE_PUSH_BACK, 32'h7fff_ffff);
    send_word(MODE_PUSH_FRONT, 32'hffff_ffff);
    send_word(MODE_PUSH_BACK, 32'h0000_0000);
    send_word(MODE_PUSH_FRONT, 32'h0000_0001);
    send_word(MODE_QUERY, 32'h5555_5555);
    send_word(MODE_POP_FRONT, 32'haaaa_aaaa);
    send_word(MODE_POP_BACK, 32'hffff_ffff);
    send_word(MODE_POP_BACK, 32'h0);
    send_word(MODE_SPARE_HI, 32'h1234_5678);
    send_word(MODE_POP_FRONT, 32'h0);
    send_word(MODE_POP_FRONT, 32'h0);
    send_word(MODE_PUSH_BACK, 32'hdead_beef);
    send_word(MODE_PUSH_FRONT, 32'h0bad_f00d);
    send_word(MODE_CLEAR, 32'h0);
    send_word(MODE_QUERY, 32'h0);
    drain_results();
  endtask

  task automatic test_fill_and_overflow();
    int k;
    send_word(MODE_CLEAR, $urandom());
    for (k = 0; k < DEPTH; k++)
      send_word(k[0] ? MODE_PUSH_BACK : MODE_PUSH_FRONT, any_value());
    send_word(MODE_PUSH_FRONT, any_value());
    send_word(MODE_PUSH_BACK, any_value());
    send_word(MODE_QUERY, $urandom());
    for (k = 0; k < DEPTH; k++)
      send_word(k[0] ? MODE_POP_FRONT : MODE_POP_BACK, $urandom());
    send_word(MODE_POP_FRONT, $urandom());
    send_word(MODE_POP_BACK, $urandom());
    drain_results();
  endtask

  task automatic test_backpressure();
    int k;
    hold_request = HOLD_CYCLES;
    for (k = 0; k < 40; k++) send_word(pick_mode(60), any_value());
    drain_results();
  endtask

  task automatic test_random_mix(input int count);
    int k;
    int push_pct;
    push_pct = 50;
    for (k = 0; k < count; k++) begin
      // drift phases let the count swing between empty and full
      if (k % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: push_pct = 20;
          1: push_pct = 50;
          default: push_pct = 80;
        endcase
      end
      if (k == count - 100) begin
        gaps_on = 1'b0;
        stalls_on = 1'b0;
      end
      send_word(pick_mode(push_pct), any_value());
    end
    drain_results();
  endtask

  // result side ready control
  initial begin : sink_ready
    int n;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
        m_axis_tready <= 1'b0;
        while (n > 0) begin
          @(negedge clk);
          n--;
          hold_served++;
        end
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    deque_view_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_views.size() == 0) begin
        report_mismatch($sformatf("unexpected result word %h", m_axis_tdata));
      end else begin
        want = expected_views.pop_front();
        words_checked++;
        if (m_axis_tdata[31:0] !== want.front_value)
          report_mismatch($sformatf("front_value %h, want %h",
                                    m_axis_tdata[31:0], want.front_value));
        if (m_axis_tdata[63:32] !== want.back_value)
          report_mismatch($sformatf("back_value %h, want %h",
                                    m_axis_tdata[63:32], want.back_value));
        if (m_axis_tdata[70:64] !== want.occupancy)
          report_mismatch($sformatf("occupancy %0d, want %0d",
                                    m_axis_tdata[70:64], want.occupancy));
        if (m_axis_tdata[72:71] !== want.status)
          report_mismatch($sformatf("status %0d, want %0d",
                                    m_axis_tdata[72:71], want.status));
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("timeout with %0d results outstanding", expected_views.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin : main_seq
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_empty_deque();
    test_both_ends();
    test_fill_and_overflow();
    test_backpressure();
    test_random_mix(400);
    repeat (12) @(posedge clk);
    if (expected_views.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_views.size()));
    $display("%0d words sent, %0d results checked, peak occupancy %0d of %0d",
             words_sent, words_checked, peak_count, DEPTH);
    $display("%0d overflow and %0d underflow results, output held off for %0d cycles",
             overflow_seen, underflow_seen, hold_served);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/dq_pkg.sv
sv/dq_ram.sv
sv/dq_ctrl.sv
sv/double_ended_queue.sv
sim/tb_double_ended_queue.sv
